// File: design/mbrf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request framer.
package mbrf_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned IDX_W      = 4;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      MODE_READ_HOLDING = 2'd0,
      MODE_WRITE_SINGLE = 2'd1,
      MODE_MULTI_HEADER = 2'd2,
      MODE_MULTI_DATA   = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_UNUSED         = 1'b1
   } csr_index_type;

   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0]  FUNC_WRITE_MULTI  = 8'h10;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  DEV_ADDR_RESET    = 8'h01;

   // Byte positions within a frame. Data-word items start at the word's
   // position, so one byte selector serves every kind of item.
   localparam idx_type POS_DEV_ADDR  = 4'd0;
   localparam idx_type POS_FUNC      = 4'd1;
   localparam idx_type POS_REG_HI    = 4'd2;
   localparam idx_type POS_REG_LO    = 4'd3;
   localparam idx_type POS_WORD_HI   = 4'd4;
   localparam idx_type POS_WORD_LO   = 4'd5;
   localparam idx_type POS_BYTE_CNT  = 4'd6;
   localparam idx_type POS_AFTER_HDR = 4'd6;
   localparam idx_type POS_AFTER_CNT = 4'd7;

   // One byte through the reflected CRC-16 with polynomial 0xA001.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: design/mbrf_req_if.sv
// Request channel: one frame item per transaction.
interface mbrf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] target_reg;
   logic [15:0] word;

   modport source (output valid, output mode, output target_reg, output word, input ready);
   modport sink   (input valid, input mode, input target_reg, input word, output ready);
endinterface

// File: design/mbrf_rsp_if.sv
// Response channel: one frame byte per transaction.
interface mbrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;

   modport source (output valid, output out_byte, output frame_end, input ready);
   modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// File: design/modbus_rtu_request_framer.sv
// Modbus RTU request framer: items in, frame bytes with CRC-16 out.
// An accepted item passes through the input register, the serializer and the
// output byte register. Throughput: one byte per cycle while the output is not
// stalled, set by the single output byte register; an item yields 8 bytes for
// single requests, 7 or 9 for a multi-write header and 2 or 4 for a data word.
// A stray data word yields no bytes. Synchronous reset clears the frame state,
// the CRC to 0xFFFF and the device address to 1.
module modbus_rtu_request_framer
   import mbrf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mbrf_req_if.sink              req_chan,
   mbrf_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------------
   // Configuration. The register index is the word address, paddr[2].
   // ---------------------------------------------------------------------
   logic [7:0]    dev_addr_ff, dev_addr_in;
   csr_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      if (csr_write && (csr_index == CSR_DEVICE_ADDRESS)) begin
         dev_addr_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DEVICE_ADDRESS: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, dev_addr_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Input register. It holds one accepted transaction until the byte
   // serializer takes it, so intake overlaps the draining of the previous
   // item's bytes.
   // ---------------------------------------------------------------------
   logic        hold_valid_ff, hold_valid_in;
   mode_type    hold_mode_ff, hold_mode_in;
   logic [15:0] hold_reg_ff, hold_reg_in;
   logic [15:0] hold_word_ff, hold_word_in;

   // Serializer: the item being sent, the position of its next byte, the
   // position of its CRC low byte and of its last byte.
   logic        busy_ff, busy_in;
   mode_type    cur_mode_ff, cur_mode_in;
   logic [15:0] cur_reg_ff, cur_reg_in;
   logic [15:0] cur_word_ff, cur_word_in;
   idx_type     cur_idx_ff, cur_idx_in;
   idx_type     cur_crc_pos_ff, cur_crc_pos_in;
   idx_type     cur_last_ff, cur_last_in;

   // Frame state carried between items.
   logic [15:0] crc_ff, crc_in;
   logic [15:0] words_left_ff, words_left_in;
   logic        frame_open_ff, frame_open_in;

   // Output byte register.
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_end_ff, out_end_in;

   logic        emit;
   logic        last_emit;
   logic        take;
   logic        stray;
   logic        is_data_byte;
   logic        is_crc_lo;
   logic [7:0]  data_byte;
   logic [7:0]  func_code;
   logic [15:0] words_dec;

   // A byte moves out when the output register is empty or being drained.
   assign emit      = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign last_emit = emit && (cur_idx_ff == cur_last_ff);
   // The held item moves on when the serializer is free or finishing.
   assign take      = hold_valid_ff && (!busy_ff || last_emit);
   // A data word with no frame open produces nothing and changes nothing.
   assign stray     = (hold_mode_ff == MODE_MULTI_DATA) && !frame_open_ff;
   assign words_dec = words_left_ff - 16'd1;

   assign req_chan.ready = !hold_valid_ff || take;

   always_comb begin
      case (cur_mode_ff)
         MODE_READ_HOLDING: func_code = FUNC_READ_HOLDING;
         MODE_WRITE_SINGLE: func_code = FUNC_WRITE_SINGLE;
         default:           func_code = FUNC_WRITE_MULTI;
      endcase
   end

   always_comb begin
      case (cur_idx_ff)
         POS_DEV_ADDR: data_byte = dev_addr_ff;
         POS_FUNC:     data_byte = func_code;
         POS_REG_HI:   data_byte = cur_reg_ff[15:8];
         POS_REG_LO:   data_byte = cur_reg_ff[7:0];
         POS_WORD_HI:  data_byte = cur_word_ff[15:8];
         POS_WORD_LO:  data_byte = cur_word_ff[7:0];
         POS_BYTE_CNT: data_byte = {cur_word_ff[6:0], 1'b0};
         default:      data_byte = 8'h00;
      endcase
   end

   assign is_data_byte = cur_idx_ff < cur_crc_pos_ff;
   assign is_crc_lo    = cur_idx_ff == cur_crc_pos_ff;

   // Input register next state.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_mode_in  = hold_mode_ff;
      hold_reg_in   = hold_reg_ff;
      hold_word_in  = hold_word_ff;
      if (take) begin
         hold_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         hold_valid_in = 1'b1;
         hold_mode_in  = mode_type'(req_chan.mode);
         hold_reg_in   = req_chan.target_reg;
         hold_word_in  = req_chan.word;
      end
   end

   // Serializer, frame state and output register next state.
   always_comb begin
      busy_in        = busy_ff;
      cur_mode_in    = cur_mode_ff;
      cur_reg_in     = cur_reg_ff;
      cur_word_in    = cur_word_ff;
      cur_idx_in     = cur_idx_ff;
      cur_crc_pos_in = cur_crc_pos_ff;
      cur_last_in    = cur_last_ff;
      crc_in         = crc_ff;
      words_left_in  = words_left_ff;
      frame_open_in  = frame_open_ff;
      out_valid_in   = out_valid_ff;
      out_byte_in    = out_byte_ff;
      out_end_in     = out_end_ff;

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      // Send one byte of the current item and fold data bytes into the CRC.
      // The CRC high byte closes the frame and restarts the CRC.
      if (emit) begin
         out_valid_in = 1'b1;
         cur_idx_in   = cur_idx_ff + 4'd1;
         if (last_emit) begin
            busy_in = 1'b0;
         end
         if (is_data_byte) begin
            out_byte_in = data_byte;
            out_end_in  = 1'b0;
            crc_in      = crc_byte(crc_ff, data_byte);
         end else if (is_crc_lo) begin
            out_byte_in = crc_ff[7:0];
            out_end_in  = 1'b0;
         end else begin
            out_byte_in = crc_ff[15:8];
            out_end_in  = 1'b1;
            crc_in      = CRC_INIT;
         end
      end

      // Move the held item into the serializer and settle the frame state
      // it leaves behind. A header drops any open frame and restarts the CRC.
      if (take && !stray) begin
         busy_in     = 1'b1;
         cur_mode_in = hold_mode_ff;
         cur_reg_in  = hold_reg_ff;
         cur_word_in = hold_word_ff;
         if (hold_mode_ff == MODE_MULTI_DATA) begin
            cur_idx_in     = POS_WORD_HI;
            cur_crc_pos_in = POS_AFTER_HDR;
            words_left_in  = words_dec;
            if (words_dec == 16'd0) begin
               cur_last_in   = POS_AFTER_HDR + 4'd1;
               frame_open_in = 1'b0;
            end else begin
               cur_last_in = POS_AFTER_HDR - 4'd1;
            end
         end else begin
            crc_in     = CRC_INIT;
            cur_idx_in = POS_DEV_ADDR;
            if (hold_mode_ff == MODE_MULTI_HEADER) begin
               cur_crc_pos_in = POS_AFTER_CNT;
               if (hold_word_ff == 16'd0) begin
                  cur_last_in   = POS_AFTER_CNT + 4'd1;
                  words_left_in = 16'd0;
                  frame_open_in = 1'b0;
               end else begin
                  cur_last_in   = POS_AFTER_CNT - 4'd1;
                  words_left_in = hold_word_ff;
                  frame_open_in = 1'b1;
               end
            end else begin
               cur_crc_pos_in = POS_AFTER_HDR;
               cur_last_in    = POS_AFTER_HDR + 4'd1;
               words_left_in  = 16'd0;
               frame_open_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff   <= DEV_ADDR_RESET;
         hold_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         crc_ff        <= CRC_INIT;
         words_left_ff <= 16'd0;
         frame_open_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         dev_addr_ff   <= dev_addr_in;
         hold_valid_ff <= hold_valid_in;
         busy_ff       <= busy_in;
         crc_ff        <= crc_in;
         words_left_ff <= words_left_in;
         frame_open_ff <= frame_open_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_mode_ff   <= hold_mode_in;
      hold_reg_ff    <= hold_reg_in;
      hold_word_ff   <= hold_word_in;
      cur_mode_ff    <= cur_mode_in;
      cur_reg_ff     <= cur_reg_in;
      cur_word_ff    <= cur_word_in;
      cur_idx_ff     <= cur_idx_in;
      cur_crc_pos_ff <= cur_crc_pos_in;
      cur_last_ff    <= cur_last_in;
      out_byte_ff    <= out_byte_in;
      out_end_ff     <= out_end_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.frame_end = out_end_ff;

endmodule
